FILE: hw/rtl/lds_pkg.sv
package lds_pkg;

  localparam int CYL_W           = 12;
  localparam int MOVE_W          = 13;
  localparam int MAX_REQ_DEF     = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef logic [CYL_W-1:0]  cyl_t;
  typedef logic [MOVE_W-1:0] move_t;

  typedef struct packed {
    cyl_t cyl;
    logic batch_end;
    logic drop;
  } req_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DOWN,
    ST_UP
  } state_t;

endpackage

FILE: hw/rtl/lds_front.sv
module lds_front import lds_pkg::*; #(
  parameter int MAX_REQ = MAX_REQ_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  cyl_t in_cylinder,
  input  logic in_batch_end,
  input  logic q_full,
  output logic q_push,
  output req_t q_entry
);

  localparam int CNT_W = $clog2(MAX_REQ + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REQ);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             full_batch;

  assign in_stall   = q_full;
  assign q_push     = in_valid && !q_full;
  assign full_batch = (cnt_r == MAX_CNT);

  always_comb begin
    q_entry.cyl       = in_cylinder;
    q_entry.batch_end = in_batch_end;
    q_entry.drop      = full_batch;
  end

  // count requests of the open batch; flag those that find the store full
  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) begin
      if (in_batch_end) begin
        cnt_nxt = '0;
      end else if (!full_batch) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/lds_queue.sv
module lds_queue import lds_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_data,
  output logic full,
  output logic pop_valid,
  input  logic pop,
  output req_t pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  req_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/lds_back.sv
module lds_back import lds_pkg::*; #(
  parameter int MAX_REQ = MAX_REQ_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  cfg_we,
  input  cyl_t  cfg_wdata,
  input  logic  q_valid,
  input  req_t  q_data,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_stall,
  output cyl_t  out_served_cylinder,
  output move_t out_movement_so_far,
  output logic  out_final_item,
  output logic  out_dropped
);

  localparam int CNT_W = $clog2(MAX_REQ + 1);
  localparam int IDX_W = $clog2(MAX_REQ);

  state_t           state_r;
  state_t           state_nxt;
  cyl_t             store_r [MAX_REQ];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  cyl_t             head_r, head_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] split_r, split_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  cyl_t             cur_r, cur_nxt;
  move_t            moved_r, moved_nxt;
  logic             out_valid_r, out_valid_nxt;
  cyl_t             out_cyl_r, out_cyl_nxt;
  move_t            out_move_r, out_move_nxt;
  logic             out_final_r, out_final_nxt;
  logic             out_drop_r, out_drop_nxt;

  logic [MAX_REQ-1:0] gt;
  logic               ins;
  logic               out_free;
  logic               emit;
  logic               scan_go;
  logic               last;
  logic               up_end;
  cyl_t               rd_data;
  cyl_t               diff;
  move_t              moved_sum;

  assign out_valid           = out_valid_r;
  assign out_served_cylinder = out_cyl_r;
  assign out_movement_so_far = out_move_r;
  assign out_final_item      = out_final_r;
  assign out_dropped         = out_drop_r;

  assign rd_data = store_r[ptr_r[IDX_W-1:0]];

  // sorted insert: entries above the new cylinder shift up one place
  for (genvar g = 0; g < MAX_REQ; g++) begin : g_ins
    assign gt[g] = (CNT_W'(g) < count_r) && (store_r[g] > q_data.cyl);
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (ins && (count_r == '0 || gt[g])) begin
          store_r[g] <= q_data.cyl;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (ins && (CNT_W'(g) == count_r || gt[g])) begin
          store_r[g] <= gt[g-1] ? store_r[g-1] : q_data.cyl;
        end
      end
    end
  end

  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    q_pop     = (state_r == ST_LOAD) && q_valid;
    ins       = q_pop && !q_data.drop;
    scan_go   = (ptr_r < count_r) && (rd_data <= head_r);
    emit      = ((state_r == ST_DOWN) || (state_r == ST_UP)) && out_free;
    last      = ((k_r + CNT_W'(1)) == count_r);
    up_end    = ((ptr_r + CNT_W'(1)) == count_r);
    diff      = (state_r == ST_DOWN) ? (cur_r - rd_data) : (rd_data - cur_r);
    moved_sum = moved_r + {1'b0, diff};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (q_pop && q_data.batch_end) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!scan_go) begin
          state_nxt = (ptr_r == '0) ? ST_UP : ST_DOWN;
        end
      end
      ST_DOWN: begin
        if (emit && ptr_r == '0) begin
          state_nxt = (split_r == count_r) ? ST_LOAD : ST_UP;
        end
      end
      ST_UP: begin
        if (emit && up_end) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    head_nxt      = cfg_we ? cfg_wdata : head_r;
    ptr_nxt       = ptr_r;
    split_nxt     = split_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    moved_nxt     = moved_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    out_cyl_nxt   = out_cyl_r;
    out_move_nxt  = out_move_r;
    out_final_nxt = out_final_r;
    out_drop_nxt  = out_drop_r;
    case (state_r)
      ST_LOAD: begin
        if (q_pop) begin
          if (q_data.drop) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          ptr_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (scan_go) begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end else begin
          split_nxt = ptr_r;
          cur_nxt   = head_r;
          moved_nxt = '0;
          k_nxt     = '0;
          ptr_nxt   = (ptr_r == '0) ? '0 : ptr_r - CNT_W'(1);
        end
      end
      ST_DOWN: begin
        if (emit) begin
          if (ptr_r == '0) begin
            if (split_r == count_r) begin
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end else begin
              ptr_nxt = split_r;
            end
          end else begin
            ptr_nxt = ptr_r - CNT_W'(1);
          end
        end
      end
      ST_UP: begin
        if (emit) begin
          if (up_end) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end else begin
            ptr_nxt = ptr_r + CNT_W'(1);
          end
        end
      end
      default: begin
        count_nxt = '0;
      end
    endcase
    if (emit) begin
      k_nxt         = k_r + CNT_W'(1);
      cur_nxt       = rd_data;
      moved_nxt     = moved_sum;
      out_valid_nxt = 1'b1;
      out_cyl_nxt   = rd_data;
      out_move_nxt  = moved_sum;
      out_final_nxt = last;
      out_drop_nxt  = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    split_r     <= split_nxt;
    k_r         <= k_nxt;
    cur_r       <= cur_nxt;
    moved_r     <= moved_nxt;
    out_cyl_r   <= out_cyl_nxt;
    out_move_r  <= out_move_nxt;
    out_final_r <= out_final_nxt;
    out_drop_r  <= out_drop_nxt;
  end

`ifndef SYNTHESIS
  a_no_insert_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    ins |-> (count_r < CNT_W'(MAX_REQ)))
    else $error("insert into a full store");

  a_down_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && state_r == ST_DOWN) |-> (rd_data <= cur_r))
    else $error("downward sweep out of order");

  a_up_above_head: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && state_r == ST_UP) |-> (rd_data > head_r && rd_data >= cur_r))
    else $error("upward sweep below head");

  a_final_closes_batch: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last) |=> (state_r == ST_LOAD && count_r == '0 && !ovf_r))
    else $error("batch not closed after final request");

  a_close_only_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DOWN || state_r == ST_UP) && state_nxt == ST_LOAD) |-> last)
    else $error("batch closed before final request");
`endif

endmodule

FILE: hw/rtl/look_disk_scheduler.sv
// Channel   | Handshake               | Payload
// ----------+-------------------------+---------------------------------------------
// request   | in_valid / in_stall     | in_cylinder[11:0], in_batch_end
// result    | out_valid / out_stall   | out_served_cylinder[11:0], out_movement_so_far[12:0],
//           |                         | out_final_item, out_dropped
// config    | cfg_we                  | cfg_wdata[11:0] (head cylinder)
//
// Requests enter a QUEUE_DEPTH-entry queue at one per cycle while it is not full; those not
// dropped are inserted into the sorted register store one per cycle while the back end loads.
// After a batch end is taken the store is scanned to locate the head, then one result per cycle
// is given for the n stored requests while out_stall is low (single store read port).
// rst_n is synchronous; it empties the queue and the store count and clears the head to 0.
// in_stall rises only when the queue is full; out_stall holds the result register.
module look_disk_scheduler import lds_pkg::*; #(
  parameter int MAX_REQUESTS = MAX_REQ_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  cfg_we,
  input  cyl_t  cfg_wdata,
  input  logic  in_valid,
  output logic  in_stall,
  input  cyl_t  in_cylinder,
  input  logic  in_batch_end,
  output logic  out_valid,
  input  logic  out_stall,
  output cyl_t  out_served_cylinder,
  output move_t out_movement_so_far,
  output logic  out_final_item,
  output logic  out_dropped
);

  logic q_full;
  logic q_push;
  req_t q_entry;
  logic q_valid;
  logic q_pop;
  req_t q_data;

  lds_front #(
    .MAX_REQ(MAX_REQUESTS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cylinder (in_cylinder),
    .in_batch_end(in_batch_end),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  lds_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_entry),
    .full     (q_full),
    .pop_valid(q_valid),
    .pop      (q_pop),
    .pop_data (q_data)
  );

  lds_back #(
    .MAX_REQ(MAX_REQUESTS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .q_valid            (q_valid),
    .q_data             (q_data),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_served_cylinder(out_served_cylinder),
    .out_movement_so_far(out_movement_so_far),
    .out_final_item     (out_final_item),
    .out_dropped        (out_dropped)
  );

endmodule
